// ===== rtl/spead_hdr_pkg.sv =====
// Constants shared by the SPEAD header decoder: header checks and item ids.
`default_nettype none
package spead_hdr_pkg;

    // Header word checks.
    localparam logic [7:0] C_MAGIC   = 8'h53;
    localparam logic [7:0] C_VERSION = 8'h04;

    // Width clamp for the id and address fields.
    localparam logic [7:0] C_MAX_WIDTH = 8'd64;

    // Item ids that the decoder acts on.
    localparam logic [63:0] C_ID_HEAP_CNT    = 64'h1;
    localparam logic [63:0] C_ID_HEAP_LEN    = 64'h2;
    localparam logic [63:0] C_ID_HEAP_ADDR   = 64'h3;
    localparam logic [63:0] C_ID_PAYLOAD_LEN = 64'h4;
    localparam logic [63:0] C_ID_STREAM_CTRL = 64'h6;
    localparam logic [63:0] C_ID_TIMESTAMPS  = 64'h6000;
    localparam logic [63:0] C_ID_BASELINES   = 64'h6005;
    localparam logic [63:0] C_ID_VIS_OFFSET  = 64'h600A;

    // Stream control value that marks the end of the stream.
    localparam logic [63:0] C_CTRL_STOP = 64'h2;

    // Result status codes.
    localparam logic C_STATUS_OK  = 1'b0;
    localparam logic C_STATUS_BAD = 1'b1;

    // Bytes taken by the header word and by one item pointer.
    localparam logic [31:0] C_WORD_BYTES = 32'd8;

endpackage
`default_nettype wire

// ===== rtl/spead_header_decoder.sv =====
// SPEAD packet header decoder: header check, item pointer decode and packet summary.
`default_nettype none
// The decoder takes one big-endian 64-bit packet word per cycle while o_stall is low:
// the header word, then the item pointers that it announces. A word is accepted at any
// edge where i_valid is high and o_stall is low, and a new word may follow every cycle
// as long as o_stall stays low. Each word is held in an input register and decoded in
// one pass; when it ends a packet, its summary word is loaded into the output register
// as the input register passes it on, and o_valid rises with it. A bad header (magic or
// version) gives a summary with status set and 8 consumed bytes at once. o_stall is
// raised only while a word that ends a packet sits in the input register and the
// previous summary is still stalled at the output.
module spead_header_decoder
    import spead_hdr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Packet word channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [63:0]        i_word,
    input  wire logic               i_nested,
    // Summary channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_status,
    output logic [31:0]             o_consumed_bytes,
    output logic signed [31:0]      o_heap_counter,
    output logic [63:0]             o_heap_len,
    output logic [63:0]             o_heap_addr,
    output logic [63:0]             o_payload_length,
    output logic                    o_stream_done,
    output logic                    o_had_stream_control,
    output logic [31:0]             o_tstamp_count,
    output logic [31:0]             o_baseline_count,
    output logic [63:0]             o_vis_offset,
    output logic [63:0]             o_dumped_bytes
);

    // Mask with the low w bits set; w is at most 64.
    function automatic logic [63:0] f_mask(input logic [6:0] w);
        logic [63:0] m;
        begin
            if (w[6]) begin
                m = '1;
            end else begin
                m = (64'h1 << w[5:0]) - 64'h1;
            end
            return m;
        end
    endfunction

    // Byte reversal of a 32-bit value.
    function automatic logic [31:0] f_swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Input register
    logic        r_in_valid;
    logic [63:0] r_in_word;
    logic        r_in_nested;

    // Parser state
    logic [7:0]  r_items_left;
    logic [7:0]  r_item_total;
    logic [6:0]  r_addr_width;
    logic [6:0]  r_id_width;
    logic        r_nested;
    logic [31:0] r_heap_cnt;
    logic        r_done;
    logic [31:0] r_timestamps;
    logic [31:0] r_baselines;
    logic [63:0] r_vis_offset;
    logic [63:0] r_dumped;
    logic [63:0] r_pkt_heap_len;
    logic [63:0] r_pkt_heap_addr;
    logic [63:0] r_pkt_payload_len;
    logic [63:0] r_pkt_vis_start;
    logic        r_pkt_ctrl_seen;

    // Output register
    logic        r_out_valid;

    // Next values
    logic [7:0]  n_items_left;
    logic [7:0]  n_item_total;
    logic [6:0]  n_addr_width;
    logic [6:0]  n_id_width;
    logic        n_nested;
    logic [31:0] n_heap_cnt;
    logic        n_done;
    logic [31:0] n_timestamps;
    logic [31:0] n_baselines;
    logic [63:0] n_vis_offset;
    logic [63:0] n_dumped;
    logic [63:0] n_pkt_heap_len;
    logic [63:0] n_pkt_heap_addr;
    logic [63:0] n_pkt_payload_len;
    logic [63:0] n_pkt_vis_start;
    logic        n_pkt_ctrl_seen;
    logic        n_emit;
    logic        n_status;
    logic [31:0] n_consumed;

    // Decode helpers
    logic [7:0]  id_bits;
    logic [7:0]  addr_bits;
    logic [63:0] item_val;
    logic [63:0] item_id;
    logic        finish;
    logic        advance;
    logic        in_accept;

    // Widths announced by the header, before clamping.
    assign id_bits   = {r_in_word[44:40], 3'b000} - 8'd1;
    assign addr_bits = {r_in_word[36:32], 3'b000};

    // Item pointer split: value in the low bits, id above it.
    assign item_val = r_in_word & f_mask(r_addr_width);
    assign item_id  = (r_in_word >> r_addr_width) & f_mask(r_id_width);

    // Decode of the word held in the input register.
    always_comb begin
        n_items_left      = r_items_left;
        n_item_total      = r_item_total;
        n_addr_width      = r_addr_width;
        n_id_width        = r_id_width;
        n_nested          = r_nested;
        n_heap_cnt        = r_heap_cnt;
        n_done            = r_done;
        n_timestamps      = r_timestamps;
        n_baselines       = r_baselines;
        n_vis_offset      = r_vis_offset;
        n_pkt_heap_len    = r_pkt_heap_len;
        n_pkt_heap_addr   = r_pkt_heap_addr;
        n_pkt_payload_len = r_pkt_payload_len;
        n_pkt_vis_start   = r_pkt_vis_start;
        n_pkt_ctrl_seen   = r_pkt_ctrl_seen;
        n_emit            = 1'b0;
        n_status          = C_STATUS_OK;
        finish            = 1'b0;

        if (r_items_left == 8'd0) begin
            // Header word: clear the per-packet fields and check the header.
            n_pkt_heap_len    = '0;
            n_pkt_heap_addr   = '0;
            n_pkt_payload_len = '0;
            n_pkt_vis_start   = '0;
            n_pkt_ctrl_seen   = 1'b0;
            if (r_in_word[63:56] != C_MAGIC || r_in_word[55:48] != C_VERSION) begin
                n_item_total = '0;
                n_emit       = 1'b1;
                n_status     = C_STATUS_BAD;
            end else begin
                n_id_width   = (id_bits > C_MAX_WIDTH) ? C_MAX_WIDTH[6:0] : id_bits[6:0];
                n_addr_width = (addr_bits > C_MAX_WIDTH) ? C_MAX_WIDTH[6:0]
                                                         : addr_bits[6:0];
                n_nested     = r_in_nested;
                n_item_total = r_in_word[7:0];
                n_items_left = r_in_word[7:0];
                finish       = (r_in_word[7:0] == 8'd0);
            end
        end else begin
            // Item pointer: act on the known ids.
            unique case (item_id)
                C_ID_HEAP_CNT: begin
                    if (!r_nested) begin
                        n_heap_cnt = item_val[31:0] - 32'd2;
                    end
                end
                C_ID_HEAP_LEN:    n_pkt_heap_len    = item_val;
                C_ID_HEAP_ADDR:   n_pkt_heap_addr   = item_val;
                C_ID_PAYLOAD_LEN: n_pkt_payload_len = item_val;
                C_ID_STREAM_CTRL: begin
                    n_pkt_ctrl_seen = 1'b1;
                    if (item_val == C_CTRL_STOP) begin
                        n_done = 1'b1;
                    end
                end
                C_ID_TIMESTAMPS: n_timestamps = f_swap32(item_val[31:0]);
                C_ID_BASELINES:  n_baselines  = f_swap32(item_val[31:0]);
                C_ID_VIS_OFFSET: begin
                    n_vis_offset    = item_val;
                    n_pkt_vis_start = item_val;
                end
                default: ;
            endcase
            n_items_left = r_items_left - 8'd1;
            finish       = (r_items_left == 8'd1);
        end

        if (finish) begin
            n_emit = 1'b1;
        end
    end

    // Packet summary: dumped visibility bytes and consumed byte count.
    always_comb begin
        n_dumped = r_dumped;
        if (finish && !n_pkt_ctrl_seen && n_vis_offset != '0 && n_baselines != '0) begin
            n_dumped = r_dumped + n_pkt_payload_len - n_pkt_vis_start;
        end
        if (n_status == C_STATUS_BAD) begin
            n_consumed = C_WORD_BYTES;
        end else begin
            n_consumed = C_WORD_BYTES + {21'd0, n_item_total, 3'b000}
                         + n_pkt_payload_len[31:0];
        end
    end

    // Flow control: the input register waits only when its word needs the output
    // register and that register is still held by the receiver.
    assign o_stall   = r_in_valid && n_emit && r_out_valid && i_stall;
    assign advance   = r_in_valid && !o_stall;
    assign in_accept = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_word   <= i_word;
            r_in_nested <= i_nested;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_left      <= '0;
            r_item_total      <= '0;
            r_addr_width      <= '0;
            r_id_width        <= '0;
            r_nested          <= 1'b0;
            r_heap_cnt        <= '0;
            r_done            <= 1'b0;
            r_timestamps      <= '0;
            r_baselines       <= '0;
            r_vis_offset      <= '0;
            r_dumped          <= '0;
            r_pkt_heap_len    <= '0;
            r_pkt_heap_addr   <= '0;
            r_pkt_payload_len <= '0;
            r_pkt_vis_start   <= '0;
            r_pkt_ctrl_seen   <= 1'b0;
        end else if (advance) begin
            r_items_left      <= n_items_left;
            r_item_total      <= n_item_total;
            r_addr_width      <= n_addr_width;
            r_id_width        <= n_id_width;
            r_nested          <= n_nested;
            r_heap_cnt        <= n_heap_cnt;
            r_done            <= n_done;
            r_timestamps      <= n_timestamps;
            r_baselines       <= n_baselines;
            r_vis_offset      <= n_vis_offset;
            r_dumped          <= n_dumped;
            r_pkt_heap_len    <= n_pkt_heap_len;
            r_pkt_heap_addr   <= n_pkt_heap_addr;
            r_pkt_payload_len <= n_pkt_payload_len;
            r_pkt_vis_start   <= n_pkt_vis_start;
            r_pkt_ctrl_seen   <= n_pkt_ctrl_seen;
        end
    end

    // Output register: loaded with the summary word, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            o_status             <= n_status;
            o_consumed_bytes     <= n_consumed;
            o_heap_counter       <= n_heap_cnt;
            o_heap_len           <= n_pkt_heap_len;
            o_heap_addr          <= n_pkt_heap_addr;
            o_payload_length     <= n_pkt_payload_len;
            o_stream_done        <= n_done;
            o_had_stream_control <= n_pkt_ctrl_seen;
            o_tstamp_count       <= n_timestamps;
            o_baseline_count     <= n_baselines;
            o_vis_offset         <= n_vis_offset;
            o_dumped_bytes       <= n_dumped;
        end
    end

    assign o_valid = r_out_valid;

    // The input side waits only behind a held summary.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a held summary");

    // The item countdown never passes the announced item count.
    a_items_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_items_left <= r_item_total)
        else $error("item countdown exceeds item count");

    // A bad header reports only the header word as consumed.
    a_bad_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_emit && n_status == C_STATUS_BAD) |=>
            (o_consumed_bytes == C_WORD_BYTES && !o_had_stream_control))
        else $error("bad header summary has wrong byte count");

    // The end-of-stream flag never clears once set.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("stream done flag cleared");

endmodule
`default_nettype wire

// ===== tb/spead_header_decoder_test.sv =====
// Self-checking testbench for the SPEAD packet header decoder.
`timescale 1ns / 100ps
module spead_header_decoder_test;
    import spead_hdr_pkg::*;

    localparam int WORD_BUDGET   = 1550;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [7:0] STD_ID_BYTES   = 8'd3;
    localparam logic [7:0] STD_ADDR_BYTES = 8'd5;

    typedef struct {
        logic [63:0] word;
        logic        nested;
    } t_packet_word;

    typedef struct {
        logic        status;
        logic [31:0] consumed;
        logic [31:0] heap_counter;
        logic [63:0] heap_len;
        logic [63:0] heap_addr;
        logic [63:0] payload_len;
        logic        done;
        logic        had_ctrl;
        logic [31:0] timestamps;
        logic [31:0] baselines;
        logic [63:0] vis_offset;
        logic [63:0] dumped;
    } t_summary;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_word = '0;
    logic        i_nested = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_status;
    logic [31:0] o_consumed_bytes;
    logic signed [31:0] o_heap_counter;
    logic [63:0] o_heap_len;
    logic [63:0] o_heap_addr;
    logic [63:0] o_payload_length;
    logic        o_stream_done;
    logic        o_had_stream_control;
    logic [31:0] o_tstamp_count;
    logic [31:0] o_baseline_count;
    logic [63:0] o_vis_offset;
    logic [63:0] o_dumped_bytes;

    spead_header_decoder i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_word               (i_word),
        .i_nested             (i_nested),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_status             (o_status),
        .o_consumed_bytes     (o_consumed_bytes),
        .o_heap_counter       (o_heap_counter),
        .o_heap_len           (o_heap_len),
        .o_heap_addr          (o_heap_addr),
        .o_payload_length     (o_payload_length),
        .o_stream_done        (o_stream_done),
        .o_had_stream_control (o_had_stream_control),
        .o_tstamp_count       (o_tstamp_count),
        .o_baseline_count     (o_baseline_count),
        .o_vis_offset         (o_vis_offset),
        .o_dumped_bytes       (o_dumped_bytes)
    );

    always #6 i_clk = ~i_clk;

    t_packet_word word_q[$];
    t_summary     summary_q[$];

    int fail_count = 0;
    int words_accepted = 0;
    int total_words = 0;
    int summaries_checked = 0;
    int packets_parsed = 0;
    int bad_headers = 0;
    int dump_updates = 0;

    // Decoder state as predicted from the accepted words.
    logic [7:0]  words_left = '0;
    logic [7:0]  item_count = '0;
    logic [7:0]  addr_bits = '0;
    logic [7:0]  id_bits = '0;
    logic        nested_pkt = 1'b0;
    logic [31:0] heap_cnt = '0;
    logic        stream_done = 1'b0;
    logic [31:0] ts_count = '0;
    logic [31:0] bl_count = '0;
    logic [63:0] vis_off = '0;
    logic [63:0] dumped_total = '0;
    logic [63:0] pkt_size = '0;
    logic [63:0] pkt_offset = '0;
    logic [63:0] pkt_len = '0;
    logic [63:0] pkt_vis_start = '0;
    logic        pkt_ctrl = 1'b0;

    function automatic logic [63:0] field_mask(input logic [7:0] bits);
        return (bits >= 8'd64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    // Id field width: id bytes times 8 minus 1, wrapped to 8 bits, then clamped.
    function automatic logic [7:0] id_field_width(input logic [7:0] nbytes);
        logic [7:0] bits;
        bits = {nbytes[4:0], 3'b000} - 8'd1;
        return (bits > C_MAX_WIDTH) ? C_MAX_WIDTH : bits;
    endfunction

    function automatic logic [7:0] addr_field_width(input logic [7:0] nbytes);
        logic [7:0] bits;
        bits = {nbytes[4:0], 3'b000};
        return (bits > C_MAX_WIDTH) ? C_MAX_WIDTH : bits;
    endfunction

    // Works out the summary, if any, that one accepted packet word causes.
    task automatic decode_packet_word(input logic [63:0] w, input logic nested);
        t_summary    s;
        logic        emit;
        logic        bad;
        logic [63:0] val;
        logic [63:0] id;
        emit = 1'b0;
        bad = 1'b0;
        if (words_left == 8'd0) begin
            pkt_size = '0;
            pkt_offset = '0;
            pkt_len = '0;
            pkt_vis_start = '0;
            pkt_ctrl = 1'b0;
            if (w[63:56] != C_MAGIC || w[55:48] != C_VERSION) begin
                item_count = '0;
                bad = 1'b1;
                emit = 1'b1;
                bad_headers++;
            end else begin
                id_bits = id_field_width(w[47:40]);
                addr_bits = addr_field_width(w[39:32]);
                nested_pkt = nested;
                item_count = w[7:0];
                words_left = item_count;
                emit = (words_left == 8'd0);
            end
        end else begin
            val = w & field_mask(addr_bits);
            id = (addr_bits >= 8'd64) ? 64'd0 : ((w >> addr_bits) & field_mask(id_bits));
            case (id)
                C_ID_HEAP_CNT: begin
                    if (!nested_pkt) heap_cnt = val[31:0] - 32'd2;
                end
                C_ID_HEAP_LEN:    pkt_size = val;
                C_ID_HEAP_ADDR:   pkt_offset = val;
                C_ID_PAYLOAD_LEN: pkt_len = val;
                C_ID_STREAM_CTRL: begin
                    pkt_ctrl = 1'b1;
                    if (val == C_CTRL_STOP) stream_done = 1'b1;
                end
                C_ID_TIMESTAMPS: ts_count = {val[7:0], val[15:8], val[23:16], val[31:24]};
                C_ID_BASELINES:  bl_count = {val[7:0], val[15:8], val[23:16], val[31:24]};
                C_ID_VIS_OFFSET: begin
                    vis_off = val;
                    pkt_vis_start = val;
                end
                default: ;
            endcase
            words_left--;
            emit = (words_left == 8'd0);
        end
        if (emit) begin
            // The dropped visibility bytes are added before the summary goes out.
            if (!bad && !pkt_ctrl && vis_off != 64'd0 && bl_count != 32'd0) begin
                dumped_total += pkt_len - pkt_vis_start;
                dump_updates++;
            end
            if (!bad) packets_parsed++;
            s.status = bad ? C_STATUS_BAD : C_STATUS_OK;
            s.consumed = bad ? C_WORD_BYTES :
                C_WORD_BYTES + C_WORD_BYTES * {24'd0, item_count} + pkt_len[31:0];
            s.heap_counter = heap_cnt;
            s.heap_len = pkt_size;
            s.heap_addr = pkt_offset;
            s.payload_len = pkt_len;
            s.done = stream_done;
            s.had_ctrl = pkt_ctrl;
            s.timestamps = ts_count;
            s.baselines = bl_count;
            s.vis_offset = vis_off;
            s.dumped = dumped_total;
            summary_q.push_back(s);
        end
    endtask

    function automatic logic [63:0] build_header(input logic [7:0] magic, input logic [7:0] version,
                                                 input logic [7:0] id_bytes,
                                                 input logic [7:0] addr_bytes,
                                                 input logic [23:0] reserved,
                                                 input logic [7:0] count);
        return {magic, version, id_bytes, addr_bytes, reserved, count};
    endfunction

    // Places id and value at the given widths; bits above both fields are filled.
    function automatic logic [63:0] build_pointer(input logic [63:0] id, input logic [63:0] val,
                                                  input logic [7:0] aw, input logic [7:0] iw,
                                                  input logic [63:0] fill);
        logic [63:0] w;
        if (aw >= 8'd64) return val;
        w = (val & field_mask(aw)) | ((id & field_mask(iw)) << aw);
        if (aw + iw < 8'd64) w |= fill & ~field_mask(aw + iw);
        return w;
    endfunction

    task automatic add_word(input logic [63:0] w, input logic n);
        t_packet_word pw;
        pw.word = w;
        pw.nested = n;
        word_q.push_back(pw);
    endtask

    function automatic logic [63:0] random_dword();
        return {$urandom, $urandom};
    endfunction

    // One well-formed packet with random widths, length and item content.
    task automatic add_random_packet();
        logic [7:0]  id_bytes;
        logic [7:0]  addr_bytes;
        logic [7:0]  count;
        logic [7:0]  aw;
        logic [7:0]  iw;
        logic [63:0] id;
        logic [63:0] val;
        logic        with_ctrl;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            id_bytes = STD_ID_BYTES;
            addr_bytes = STD_ADDR_BYTES;
        end else if (r < 70) begin
            id_bytes = 8'd2;
            addr_bytes = 8'd6;
        end else if (r < 90) begin
            id_bytes = 8'($urandom_range(0, 9));
            addr_bytes = 8'($urandom_range(0, 9));
        end else begin
            id_bytes = 8'($urandom);
            addr_bytes = 8'($urandom);
        end
        iw = id_field_width(id_bytes);
        aw = addr_field_width(addr_bytes);

        // Mostly short packets, now and then empty or very long ones.
        r = $urandom_range(0, 99);
        if (r < 2)       count = 8'($urandom_range(128, 255));
        else if (r < 10) count = 8'd0;
        else if (r < 25) count = 8'($urandom_range(9, 30));
        else             count = 8'($urandom_range(1, 8));
        with_ctrl = ($urandom_range(0, 6) == 0);

        add_word(build_header(C_MAGIC, C_VERSION, id_bytes, addr_bytes, 24'($urandom), count),
                 $urandom_range(0, 2) == 0);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 19);
            if (i == 0 && with_ctrl) id = C_ID_STREAM_CTRL;
            else if (r < 2)  id = C_ID_HEAP_CNT;
            else if (r < 4)  id = C_ID_HEAP_LEN;
            else if (r < 6)  id = C_ID_HEAP_ADDR;
            else if (r < 8)  id = C_ID_PAYLOAD_LEN;
            else if (r < 10) id = C_ID_TIMESTAMPS;
            else if (r < 12) id = C_ID_BASELINES;
            else if (r < 15) id = C_ID_VIS_OFFSET;
            else             id = random_dword();
            r = $urandom_range(0, 9);
            if (id == C_ID_STREAM_CTRL && r < 3) val = C_CTRL_STOP;
            else if (r == 0) val = '0;
            else if (r == 1) val = '1;
            else if (r == 2) val = 64'd2;
            else if (r < 6)  val = 64'($urandom_range(1, 4096));
            else             val = random_dword();
            add_word(build_pointer(id, val, aw, iw, random_dword()), 1'($urandom_range(0, 1)));
        end
    endtask

    // Packet words go to the decoder in bursts with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_packet_word pw;
        int           r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_packet_word(i_word, i_nested);
                words_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (burst_left == 0 && gap_left == 0) begin
                    r = $urandom_range(0, 9);
                    burst_left = (r < 2) ? $urandom_range(50, 200) : $urandom_range(1, 12);
                    r = $urandom_range(0, 9);
                    gap_left = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 15);
                end
                if (burst_left > 0 && word_q.size() > 0) begin
                    pw = word_q.pop_front();
                    i_word <= pw.word;
                    i_nested <= pw.nested;
                    i_valid <= 1'b1;
                    burst_left--;
                end else begin
                    i_valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0) gap_left--;
                end
            end
        end
    end

    // The summary side stalls in stretches of differing density.
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_run = $urandom_range(20, 120);
            end
            stall_run--;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
                default:     i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
            fail_count++;
        end
    endtask

    // Each accepted summary is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_summary s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (summary_q.size() == 0) begin
                $display("%0t: summary with none predicted, status %b consumed %h",
                         $time, o_status, o_consumed_bytes);
                fail_count++;
            end else begin
                s = summary_q.pop_front();
                summaries_checked++;
                check_field("status", 64'(s.status), 64'(o_status));
                check_field("consumed_bytes", 64'(s.consumed), 64'(o_consumed_bytes));
                check_field("heap_counter", 64'(s.heap_counter),
                            64'($unsigned(o_heap_counter)));
                check_field("heap_len", s.heap_len, o_heap_len);
                check_field("heap_addr", s.heap_addr, o_heap_addr);
                check_field("payload_length", s.payload_len, o_payload_length);
                check_field("stream_done", 64'(s.done), 64'(o_stream_done));
                check_field("had_stream_control", 64'(s.had_ctrl),
                            64'(o_had_stream_control));
                check_field("tstamp_count", 64'(s.timestamps), 64'(o_tstamp_count));
                check_field("baseline_count", 64'(s.baselines), 64'(o_baseline_count));
                check_field("vis_offset", s.vis_offset, o_vis_offset);
                check_field("dumped_bytes", s.dumped, o_dumped_bytes);
            end
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d of %0d words accepted",
                         $time, idle_cycles, words_accepted, total_words);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] aw;
        logic [7:0] iw;
        int         r;
        aw = addr_field_width(STD_ADDR_BYTES);
        iw = id_field_width(STD_ID_BYTES);

        // Bad headers: all zeros, all ones, wrong version, wrong magic.
        add_word('0, 1'b0);
        add_word('1, 1'b1);
        add_word(build_header(C_MAGIC, 8'd3, STD_ID_BYTES, STD_ADDR_BYTES, '0, 8'd4), 1'b0);
        add_word(build_header(8'h52, C_VERSION, STD_ID_BYTES, STD_ADDR_BYTES, '1, 8'd0), 1'b0);
        // A packet with no items is summarized on its header.
        add_word(build_header(C_MAGIC, C_VERSION, STD_ID_BYTES, STD_ADDR_BYTES, '1, 8'd0), 1'b0);
        // All known ids but stream control, and unknown ones, so bytes are dumped.
        add_word(build_header(C_MAGIC, C_VERSION, STD_ID_BYTES, STD_ADDR_BYTES, '0, 8'd9), 1'b0);
        add_word(build_pointer(C_ID_HEAP_CNT, '0, aw, iw, '1), 1'b1);
        add_word(build_pointer(C_ID_HEAP_LEN, '1, aw, iw, '0), 1'b0);
        add_word(build_pointer(C_ID_HEAP_ADDR, 64'h123, aw, iw, '1), 1'b0);
        add_word(build_pointer(C_ID_PAYLOAD_LEN, 64'h40, aw, iw, '0), 1'b1);
        add_word(build_pointer(C_ID_TIMESTAMPS, 64'h1122_3344, aw, iw, '1), 1'b0);
        add_word(build_pointer(C_ID_BASELINES, 64'h0A0B_0C0D, aw, iw, '0), 1'b0);
        add_word(build_pointer(C_ID_VIS_OFFSET, 64'h10, aw, iw, '1), 1'b0);
        add_word(build_pointer(64'h7F_FFFF, '1, aw, iw, '1), 1'b1);
        add_word(build_pointer(64'h5, 64'd7, aw, iw, '0), 1'b0);
        // Nested packet: the heap counter holds; stream stop sets the done flag.
        add_word(build_header(C_MAGIC, C_VERSION, STD_ID_BYTES, STD_ADDR_BYTES, '0, 8'd2), 1'b1);
        add_word(build_pointer(C_ID_HEAP_CNT, 64'd100, aw, iw, '0), 1'b0);
        add_word(build_pointer(C_ID_STREAM_CTRL, C_CTRL_STOP, aw, iw, '0), 1'b0);
        // A 64-bit address width leaves every id at zero.
        add_word(build_header(C_MAGIC, C_VERSION, 8'd1, 8'd8, '0, 8'd1), 1'b0);
        add_word('1, 1'b1);
        // Wrapped widths: no address bits, and the id takes the whole word.
        add_word(build_header(C_MAGIC, C_VERSION, 8'd0, 8'd32, '0, 8'd2), 1'b0);
        add_word(build_pointer(C_ID_HEAP_CNT, '0, 8'd0, 8'd64, '0), 1'b0);
        add_word(build_pointer(C_ID_TIMESTAMPS, '0, 8'd0, 8'd64, '0), 1'b0);
        // Stream control with a value other than stop.
        add_word(build_header(C_MAGIC, C_VERSION, STD_ID_BYTES, STD_ADDR_BYTES, '0, 8'd1), 1'b0);
        add_word(build_pointer(C_ID_STREAM_CTRL, 64'd3, aw, iw, '1), 1'b0);

        // Random part: mostly well-formed packets, with bad headers between them.
        while (word_q.size() < WORD_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                add_word(random_dword(), 1'($urandom_range(0, 1)));
            end else if (r < 5) begin
                add_word(build_header(C_MAGIC, 8'($urandom_range(5, 255)), 8'($urandom),
                                      8'($urandom), 24'($urandom), 8'($urandom)), 1'b0);
            end else if (r < 7) begin
                add_word(build_header(8'($urandom_range(0, 8'h52)), C_VERSION, 8'($urandom),
                                      8'($urandom), 24'($urandom), 8'($urandom)), 1'b1);
            end
            add_random_packet();
        end
        total_words = word_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < total_words || summary_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d parsed packets and %0d bad headers.",
                 total_words, packets_parsed, bad_headers);
        $display("Checked %0d summaries, %0d of them with dropped visibility bytes.",
                 summaries_checked, dump_updates);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spead_hdr_pkg.sv
rtl/spead_header_decoder.sv
tb/spead_header_decoder_test.sv
